[rtl/core/bor_pkg.sv]
// Shared types and constants for the box overlap ratio unit.
package bor_pkg;

  // Width of the overlap rank field.
  localparam int unsigned RANK_W = 4;

  // Number of rank thresholds.
  localparam int unsigned N_RANK = 11;

  // Scale of the thresholds: each threshold is given in hundredths.
  localparam int unsigned THRESH_SCALE = 100;

  // Bits needed to hold the largest threshold or the scale.
  localparam int unsigned THRESH_W = 7;

  // Thresholds in hundredths, from the lowest, with the rank that each gives.
  localparam int unsigned RANK_THRESH [N_RANK] = '{1, 10, 20, 30, 40, 50, 60, 70, 80, 90, 101};
  localparam int unsigned RANK_VALUE  [N_RANK] = '{10, 9, 8, 7, 6, 5, 4, 3, 2, 1, 0};

  // Control information that travels with each item down the pipeline.
  typedef struct packed {
    logic              mode;
    logic              degen;
    logic [RANK_W-1:0] rank;
  } bor_ctrl_t;

endpackage

[rtl/core/bor_ifs.sv]
// Valid/ready channel interfaces for box pairs and overlap results.
interface bor_box_if import bor_pkg::*; #(
  parameter int unsigned COORD_BITS = 12
);
  logic                  valid;
  logic                  ready;
  logic                  mode;
  logic signed [COORD_BITS:0] a_x;
  logic signed [COORD_BITS:0] a_y;
  logic [COORD_BITS-1:0] a_w;
  logic [COORD_BITS-1:0] a_h;
  logic signed [COORD_BITS:0] b_x;
  logic signed [COORD_BITS:0] b_y;
  logic [COORD_BITS-1:0] b_w;
  logic [COORD_BITS-1:0] b_h;

  modport source (output valid, mode, a_x, a_y, a_w, a_h, b_x, b_y, b_w, b_h,
                  input ready);
  modport sink (input valid, mode, a_x, a_y, a_w, a_h, b_x, b_y, b_w, b_h,
                output ready);
endinterface

interface bor_res_if import bor_pkg::*; #(
  parameter int unsigned FRAC_BITS = 16
);
  logic                 valid;
  logic                 ready;
  logic [FRAC_BITS:0]   ratio;
  logic [RANK_W-1:0]    overlap_rank;
  logic                 degenerate;

  modport source (output valid, ratio, overlap_rank, degenerate, input ready);
  modport sink (input valid, ratio, overlap_rank, degenerate, output ready);
endinterface

[rtl/core/bor_geom.sv]
// Geometry stages: intersection spans, areas, intersection and denominator.
module bor_geom import bor_pkg::*; #(
  parameter int unsigned COORD_BITS = 12
) (
  input  logic                      clk,
  input  logic                      rst,
  bor_box_if.sink                   in_box,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [2*COORD_BITS-1:0]   inter,
  output logic [2*COORD_BITS:0]     den,
  output bor_ctrl_t                 ctrl
);

  localparam int unsigned C  = COORD_BITS;
  localparam int unsigned AW = 2 * COORD_BITS;
  localparam int unsigned DW = 2 * COORD_BITS + 1;

  // Stage 1: spans.
  logic signed [C+1:0] ea_x, eb_x, ea_y, eb_y, hi_x, hi_y;
  logic signed [C:0]   lo_x, lo_y;
  logic signed [C+2:0] dx, dy;
  logic                v1, rdy1;
  logic                mode1, ovl1;
  logic [C-1:0]        dx1, dy1, aw1, ah1, bw1, bh1;

  // Stage 2: products.
  logic                v2, rdy2;
  logic                mode2;
  logic [AW-1:0]       inter2, area_a2, area_b2;

  // Stage 3: denominator.
  logic                v3, rdy3;
  logic [DW-1:0]       den_next;

  always_comb begin
    ea_x = (C+2)'(in_box.a_x) + $signed({2'b00, in_box.a_w});
    eb_x = (C+2)'(in_box.b_x) + $signed({2'b00, in_box.b_w});
    ea_y = (C+2)'(in_box.a_y) + $signed({2'b00, in_box.a_h});
    eb_y = (C+2)'(in_box.b_y) + $signed({2'b00, in_box.b_h});
    lo_x = (in_box.a_x > in_box.b_x) ? in_box.a_x : in_box.b_x;
    lo_y = (in_box.a_y > in_box.b_y) ? in_box.a_y : in_box.b_y;
    hi_x = (ea_x < eb_x) ? ea_x : eb_x;
    hi_y = (ea_y < eb_y) ? ea_y : eb_y;
    dx   = (C+3)'(hi_x) - (C+3)'(lo_x);
    dy   = (C+3)'(hi_y) - (C+3)'(lo_y);
  end

  assign rdy3      = !v3 || out_ready;
  assign rdy2      = !v2 || rdy3;
  assign rdy1      = !v1 || rdy2;
  assign in_box.ready = rdy1;
  assign out_valid = v3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (rdy1) v1 <= in_box.valid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
    end
  end

  // A non-negative span never exceeds the width of the first box, so the
  // low bits hold it exactly.
  always_ff @(posedge clk) begin
    if (rdy1 && in_box.valid) begin
      mode1 <= in_box.mode;
      ovl1  <= !dx[C+2] && !dy[C+2];
      dx1   <= dx[C-1:0];
      dy1   <= dy[C-1:0];
      aw1   <= in_box.a_w;
      ah1   <= in_box.a_h;
      bw1   <= in_box.b_w;
      bh1   <= in_box.b_h;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2 && v1) begin
      mode2   <= mode1;
      inter2  <= ovl1 ? AW'(dx1 * dy1) : '0;
      area_a2 <= AW'(aw1 * ah1);
      area_b2 <= AW'(bw1 * bh1);
    end
  end

  // The union never goes negative, since the intersection is no larger
  // than either area.
  assign den_next = mode2 ? DW'(area_a2)
                          : DW'(area_a2) + DW'(area_b2) - DW'(inter2);

  always_ff @(posedge clk) begin
    if (rdy3 && v2) begin
      inter      <= inter2;
      den        <= den_next;
      ctrl.mode  <= mode2;
      ctrl.degen <= (den_next == '0);
      ctrl.rank  <= '0;
    end
  end

endmodule

[rtl/core/bor_rank.sv]
// Rank stages: exact cross-multiplied comparison against the thresholds.
module bor_rank import bor_pkg::*; #(
  parameter int unsigned COORD_BITS = 12
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [2*COORD_BITS-1:0]   in_inter,
  input  logic [2*COORD_BITS:0]     in_den,
  input  bor_ctrl_t                 in_ctrl,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [2*COORD_BITS-1:0]   inter,
  output logic [2*COORD_BITS:0]     den,
  output bor_ctrl_t                 ctrl
);

  localparam int unsigned AW = 2 * COORD_BITS;
  localparam int unsigned DW = 2 * COORD_BITS + 1;
  localparam int unsigned PW = DW + THRESH_W;

  logic                v1, rdy1, v2, rdy2;
  logic [PW-1:0]       prod1 [N_RANK];
  logic [PW-1:0]       scaled1;
  logic [AW-1:0]       inter1;
  logic [DW-1:0]       den1;
  bor_ctrl_t           ctrl1;
  logic [N_RANK-1:0]   le;
  logic [RANK_W-1:0]   rank_enc;

  assign rdy2      = !v2 || out_ready;
  assign rdy1      = !v1 || rdy2;
  assign in_ready  = rdy1;
  assign out_valid = v2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      if (rdy1) v1 <= in_valid;
      if (rdy2) v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) begin
      for (int i = 0; i < N_RANK; i++) begin
        prod1[i] <= PW'(in_den) * PW'(RANK_THRESH[i]);
      end
      scaled1 <= PW'(in_inter) * PW'(THRESH_SCALE);
      inter1  <= in_inter;
      den1    <= in_den;
      ctrl1   <= in_ctrl;
    end
  end

  // The first threshold that the fraction does not exceed sets the rank.
  always_comb begin
    rank_enc = '0;
    for (int i = 0; i < N_RANK; i++) begin
      le[i] = (scaled1 <= prod1[i]);
    end
    for (int i = N_RANK - 1; i >= 0; i--) begin
      if (le[i]) rank_enc = RANK_W'(RANK_VALUE[i]);
    end
  end

  // A degenerate item is given a full-scale divisor and a zero dividend, so
  // that the divider yields a zero quotient for it.
  always_ff @(posedge clk) begin
    if (rdy2 && v1) begin
      inter      <= ctrl1.degen ? '0 : inter1;
      den        <= ctrl1.degen ? '1 : den1;
      ctrl.mode  <= ctrl1.mode;
      ctrl.degen <= ctrl1.degen;
      ctrl.rank  <= (ctrl1.mode && !ctrl1.degen) ? rank_enc : '0;
    end
  end

endmodule

[rtl/core/bor_div.sv]
// Pipelined restoring divider: one quotient bit per stage.
module bor_div import bor_pkg::*; #(
  parameter int unsigned COORD_BITS = 12,
  parameter int unsigned FRAC_BITS  = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [2*COORD_BITS-1:0]   in_inter,
  input  logic [2*COORD_BITS:0]     in_den,
  input  bor_ctrl_t                 in_ctrl,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [FRAC_BITS:0]        quot,
  output bor_ctrl_t                 ctrl
);

  localparam int unsigned DW = 2 * COORD_BITS + 1;
  localparam int unsigned QW = FRAC_BITS + 1;

  logic            v   [QW];
  logic            rdy [QW];
  logic [DW-1:0]   rem [QW];
  logic [DW-1:0]   dvs [QW];
  logic [QW-1:0]   q   [QW];
  bor_ctrl_t       cs  [QW];

  // The quotient never exceeds one, so the bits above the top quotient bit
  // are zero and the first partial remainder is the intersection itself.
  for (genvar j = 0; j < QW; j++) begin : g_stage
    logic          up_valid, down_ready;
    logic [DW-1:0] up_den;
    logic [QW-1:0] up_q;
    bor_ctrl_t     up_ctrl;
    logic [DW:0]   trial, diff;
    logic          ge;

    if (j == 0) begin : g_first
      assign up_valid = in_valid;
      assign up_den   = in_den;
      assign up_q     = '0;
      assign up_ctrl  = in_ctrl;
      assign trial    = (DW+1)'(in_inter);
    end else begin : g_next
      assign up_valid = v[j-1];
      assign up_den   = dvs[j-1];
      assign up_q     = q[j-1];
      assign up_ctrl  = cs[j-1];
      assign trial    = {rem[j-1], 1'b0};
    end

    if (j == QW - 1) begin : g_last
      assign down_ready = out_ready;
    end else begin : g_mid
      assign down_ready = rdy[j+1];
    end

    assign diff   = trial - {1'b0, up_den};
    assign ge     = (trial >= {1'b0, up_den});
    assign rdy[j] = !v[j] || down_ready;

    always_ff @(posedge clk) begin
      if (rst) begin
        v[j] <= 1'b0;
      end else if (rdy[j]) begin
        v[j] <= up_valid;
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[j] && up_valid) begin
        rem[j] <= ge ? diff[DW-1:0] : trial[DW-1:0];
        dvs[j] <= up_den;
        q[j]   <= {up_q[QW-2:0], ge};
        cs[j]  <= up_ctrl;
      end
    end
  end

  assign in_ready  = rdy[0];
  assign out_valid = v[QW-1];
  assign quot      = q[QW-1];
  assign ctrl      = cs[QW-1];

endmodule

[rtl/core/box_overlap_ratio_unit.sv]
// Pipeline: three geometry stages, two rank stages and one divider stage per quotient
//   bit, between input transfer and result.
// Throughput: one box pair per cycle while the output is not stalled; the divider's
//   FRAC_BITS + 1 stages each resolve one quotient bit, so every stage can take a new pair each cycle.
// Reset: rst is synchronous and active high; it empties every pipeline stage.
// Top level: overlap ratio of two axis-aligned boxes, with rank in mode 1.
module box_overlap_ratio_unit import bor_pkg::*; #(
  parameter int unsigned COORD_BITS = 12,
  parameter int unsigned FRAC_BITS  = 16
) (
  input  logic       clk,
  input  logic       rst,
  bor_box_if.sink    in_box,
  bor_res_if.source  out_res
);

  localparam int unsigned AW = 2 * COORD_BITS;
  localparam int unsigned DW = 2 * COORD_BITS + 1;

  // Geometry to rank.
  logic          g_valid, g_ready;
  logic [AW-1:0] g_inter;
  logic [DW-1:0] g_den;
  bor_ctrl_t     g_ctrl;

  // Rank to divider.
  logic          r_valid, r_ready;
  logic [AW-1:0] r_inter;
  logic [DW-1:0] r_den;
  bor_ctrl_t     r_ctrl;

  // Divider output.
  logic               d_valid;
  logic [FRAC_BITS:0] d_quot;
  bor_ctrl_t          d_ctrl;

  // The first three stages form the spans, the areas, the intersection and
  // the denominator, which is the union in mode 0 and the first box's area
  // in mode 1. A zero denominator is flagged there.
  bor_geom #(
    .COORD_BITS (COORD_BITS)
  ) u_geom (
    .clk       (clk),
    .rst       (rst),
    .in_box    (in_box),
    .out_valid (g_valid),
    .out_ready (g_ready),
    .inter     (g_inter),
    .den       (g_den),
    .ctrl      (g_ctrl)
  );

  // The next two stages compare one hundred times the intersection with
  // each threshold times the denominator, so the rank is exact rather than
  // derived from the truncated ratio.
  bor_rank #(
    .COORD_BITS (COORD_BITS)
  ) u_rank (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (g_valid),
    .in_ready  (g_ready),
    .in_inter  (g_inter),
    .in_den    (g_den),
    .in_ctrl   (g_ctrl),
    .out_valid (r_valid),
    .out_ready (r_ready),
    .inter     (r_inter),
    .den       (r_den),
    .ctrl      (r_ctrl)
  );

  // The divider's last stage is the output register. Each stage holds its
  // item while the stage below is full and stalled, and takes a new one as
  // soon as it is empty, so bubbles close up and a waiting result does not
  // stop transfers further up.
  bor_div #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (r_valid),
    .in_ready  (r_ready),
    .in_inter  (r_inter),
    .in_den    (r_den),
    .in_ctrl   (r_ctrl),
    .out_valid (d_valid),
    .out_ready (out_res.ready),
    .quot      (d_quot),
    .ctrl      (d_ctrl)
  );

  // A degenerate item reaches here with a zero quotient and a zero rank.
  assign out_res.valid        = d_valid;
  assign out_res.ratio        = d_quot;
  assign out_res.overlap_rank = d_ctrl.rank;
  assign out_res.degenerate   = d_ctrl.degen;

endmodule

[rtl/core/bor_checker.sv]
// Port-level checks on the box overlap ratio unit, bound to its top level.
module bor_checker import bor_pkg::*; #(
  parameter int unsigned FRAC_BITS = 16
) (
  input logic                 clk,
  input logic                 rst,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic [FRAC_BITS:0]   ratio,
  input logic [RANK_W-1:0]    overlap_rank,
  input logic                 degenerate
);

  localparam int unsigned SW = FRAC_BITS + 1 + THRESH_W;
  localparam logic [FRAC_BITS:0] ONE = (FRAC_BITS+1)'(1) << FRAC_BITS;

  // A degenerate result carries neither ratio nor rank.
  a_degen_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && degenerate |-> ratio == '0 && overlap_rank == '0)
    else $error("degenerate result with non-zero ratio or rank");

  // The ratio never exceeds one.
  a_ratio_max: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ratio <= ONE)
    else $error("ratio above one");

  // The lowest-overlap rank means a fraction of at most one hundredth.
  a_rank_low: assert property (@(posedge clk) disable iff (rst)
    out_valid && overlap_rank == RANK_W'(RANK_VALUE[0])
      |-> SW'(ratio) * SW'(THRESH_SCALE) <= SW'(ONE))
    else $error("lowest rank with ratio above one hundredth");

  // A full overlap always has rank zero.
  a_full_rank: assert property (@(posedge clk) disable iff (rst)
    out_valid && ratio == ONE |-> overlap_rank == '0)
    else $error("full overlap with non-zero rank");

  // A stalled result holds until it is transferred.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(ratio)
      && $stable(overlap_rank) && $stable(degenerate))
    else $error("stalled result changed");

endmodule

bind box_overlap_ratio_unit bor_checker #(
  .FRAC_BITS (FRAC_BITS)
) u_bor_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_res.valid),
  .out_ready    (out_res.ready),
  .ratio        (out_res.ratio),
  .overlap_rank (out_res.overlap_rank),
  .degenerate   (out_res.degenerate)
);
